### rtl/sorf_pkg.sv
// Shared constants for the second-order recursive filter unit.
// No dependencies; used by the filter top level.
package sorf_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int OUT_W     = 32;
	localparam int POS_W     = 6;
	localparam int PROD_W    = 2 * COEF_W;
	localparam int ACC_W     = PROD_W + 3;
	localparam int FRAC_BITS = 30;
	localparam int FILL_W    = 7;
	localparam int MAX_LEN   = 64;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	localparam logic [2:0] REG_NUM1 = 3'd0;
	localparam logic [2:0] REG_NUM2 = 3'd1;
	localparam logic [2:0] REG_DEN1 = 3'd2;
	localparam logic [2:0] REG_DEN2 = 3'd3;
	localparam logic [2:0] REG_MODE = 3'd4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

endpackage

### rtl/sorf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the reverse-mode series buffer.
module sorf_ram #(
	parameter int Width = 24,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/second_order_recursive_filter_unit.sv
// Top level of the second-order recursive filter unit (direct form 1 biquad).
// Depends on sorf_pkg and sorf_ram.
//
// Filters signed 24-bit samples with y = x + num1*x1 + num2*x2 - den1*y1 - den2*y2,
// Q2.30 coefficients, rounded and saturated to 32 bits. One shared 32x32 multiplier
// forms the four products in turn under a small sequencer: after acceptance it runs
// four products plus one accumulate, then a finish state that holds while the output
// is stalled, and loads the result; the input is not ready meanwhile. In reverse mode
// a sample that does not close a run is only buffered; a closing sample starts a backward
// pass over the buffer, each result taking one RAM read, five multiply/accumulate steps
// and one finish state that holds while the output is stalled. Filter history is kept
// across series and cleared by reset only; writing reverse_mode drops any partly
// buffered series.
module second_order_recursive_filter_unit
	import sorf_pkg::*;
#(
	parameter int MaxLen = sorf_pkg::MAX_LEN
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [23:0] sample_in
	input  logic                   s_tlast,   // series_end
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] sample_out, [37:32] position, 0 pad
	output logic                   m_tlast,   // run_last
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ADDR_W-1:0]      paddr,
	input  logic [DATA_W-1:0]      pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	localparam int AW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

	logic signed [COEF_W-1:0]   num1_q, num2_q, den1_q, den2_q;
	logic                       rev_q;
	logic signed [SAMPLE_W-1:0] in1_q, in2_q;
	logic signed [OUT_W-1:0]    out1_q, out2_q;
	logic [FILL_W-1:0]          fill_q;
	logic [1:0]                 state_q;
	logic [2:0]                 step_q;
	logic [AW-1:0]              k_q;
	logic                       run_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic [POS_W-1:0]           pos_q;
	logic                       last_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic                       sub_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       out_valid_q;
	logic signed [OUT_W-1:0]    y_out_q;
	logic [POS_W-1:0]           pos_out_q;
	logic                       last_out_q;

	logic [2:0]                 reg_idx;
	logic                       cfg_wr;
	logic                       in_acc;
	logic [FILL_W-1:0]          fill_inc;
	logic                       run_close;
	logic [SAMPLE_W-1:0]        rd_data;
	logic signed [SAMPLE_W-1:0] x_cur;
	logic signed [COEF_W-1:0]   coef_sel, val_sel;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-FRAC_BITS:0] y_wide;
	logic signed [OUT_W-1:0]    y_sat;
	logic                       out_free;
	logic                       finish;

	assign reg_idx   = paddr[4:2];
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign fill_inc  = fill_q + FILL_W'(1);
	assign run_close = s_tlast || (fill_inc == FILL_W'(MaxLen));
	assign out_free  = !out_valid_q || m_tready;
	assign finish    = (state_q == ST_DONE) && out_free;

	sorf_ram #(
		.Width(SAMPLE_W),
		.Depth(MaxLen)
	) u_buf (
		.clk  (clk),
		.we   (in_acc && rev_q),
		.waddr(fill_q[AW-1:0]),
		.wdata(s_tdata[SAMPLE_W-1:0]),
		.re   (state_q == ST_READ),
		.raddr(k_q),
		.rdata(rd_data)
	);

	assign x_cur = run_q ? $signed(rd_data) : x_q;

	always_comb begin
		case (step_q)
			3'd0: begin
				coef_sel = num1_q;
				val_sel  = COEF_W'(in1_q);
			end
			3'd1: begin
				coef_sel = num2_q;
				val_sel  = COEF_W'(in2_q);
			end
			3'd2: begin
				coef_sel = den1_q;
				val_sel  = out1_q;
			end
			default: begin
				coef_sel = den2_q;
				val_sel  = out2_q;
			end
		endcase
	end

	assign prod_ext = ACC_W'(prod_s1);
	assign y_wide   = (ACC_W-FRAC_BITS+1)'(acc_q >>> FRAC_BITS)
		+ (ACC_W-FRAC_BITS+1)'(x_cur);

	always_comb begin
		if (!y_wide[ACC_W-FRAC_BITS] && (|y_wide[ACC_W-FRAC_BITS-1:OUT_W-1])) begin
			y_sat = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (y_wide[ACC_W-FRAC_BITS] && !(&y_wide[ACC_W-FRAC_BITS-1:OUT_W-1])) begin
			y_sat = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			y_sat = y_wide[OUT_W-1:0];
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NUM1: prdata = num1_q;
			REG_NUM2: prdata = num2_q;
			REG_DEN1: prdata = den1_q;
			REG_DEN2: prdata = den2_q;
			REG_MODE: prdata = DATA_W'(rev_q);
			default:  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num1_q      <= '0;
			num2_q      <= '0;
			den1_q      <= '0;
			den2_q      <= '0;
			rev_q       <= 1'b0;
			in1_q       <= '0;
			in2_q       <= '0;
			out1_q      <= '0;
			out2_q      <= '0;
			fill_q      <= '0;
			state_q     <= ST_IDLE;
			step_q      <= '0;
			k_q         <= '0;
			run_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (reg_idx)
					REG_NUM1: num1_q <= pwdata;
					REG_NUM2: num2_q <= pwdata;
					REG_DEN1: den1_q <= pwdata;
					REG_DEN2: den2_q <= pwdata;
					REG_MODE: begin
						rev_q  <= pwdata[0];
						fill_q <= '0;
					end
					default: ;
				endcase
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_acc) begin
						if (!rev_q) begin
							fill_q  <= s_tlast ? '0 : (fill_inc & FILL_W'(2**POS_W - 1));
							run_q   <= 1'b0;
							state_q <= ST_MUL;
						end else if (run_close) begin
							k_q     <= fill_q[AW-1:0];
							fill_q  <= '0;
							run_q   <= 1'b1;
							state_q <= ST_READ;
						end else begin
							fill_q <= fill_inc;
						end
					end
				end
				ST_READ: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						in2_q  <= in1_q;
						in1_q  <= x_cur;
						out2_q <= out1_q;
						out1_q <= y_sat;
						if (run_q && (k_q != '0)) begin
							k_q     <= k_q - AW'(1);
							state_q <= ST_READ;
						end else begin
							run_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= s_tdata[SAMPLE_W-1:0];
			pos_q  <= fill_q[POS_W-1:0];
			last_q <= s_tlast;
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= coef_sel * val_sel;
			sub_s1  <= step_q[1];
			if (step_q != 3'd0) begin
				acc_q <= sub_s1 ? (acc_q - prod_ext) : (acc_q + prod_ext);
			end
		end else if (state_q != ST_DONE) begin
			// seed with half an LSB: round to nearest, ties up
			acc_q <= ACC_W'(2**(FRAC_BITS-1));
		end
		if (finish) begin
			y_out_q    <= y_sat;
			pos_out_q  <= run_q ? POS_W'(k_q) : pos_q;
			last_out_q <= run_q ? (k_q == '0) : last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-OUT_W-POS_W){1'b0}}, pos_out_q, y_out_q};
	assign m_tlast  = last_out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rev_q |-> (fill_q < FILL_W'(MaxLen)))
		else $error("fill count reached buffer depth in reverse mode");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (step_q <= 3'd4))
		else $error("sequencer step out of range");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result loaded outside finish state");

endmodule
